// ===== hw/rtl/cubic_prism_outline_tessellator_assert.svh =====
// Assertion macros for the outline tessellator.
`ifndef CUBIC_PRISM_OUTLINE_TESSELLATOR_ASSERT_SVH
`define CUBIC_PRISM_OUTLINE_TESSELLATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CPOT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CPOT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CPOT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CPOT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cpot_pkg.sv =====
package cpot_pkg;

  localparam int MAX_STEPS  = 63;
  localparam int STEP_W     = 6;
  localparam int INC_W      = 17;
  localparam int COEF_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_INCREMENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONIC_MODE      = 3'd4;

  // datapath widths
  localparam int R_W    = STEP_W + INC_W;      // r = k * increment
  localparam int RR_W   = 2 * R_W;             // r * r
  localparam int R2_W   = RR_W - FRAC_W;       // r^2
  localparam int R2R_W  = R2_W + R_W;          // r^2 * r
  localparam int R3_W   = R2R_W - FRAC_W;      // r^3
  localparam int HI_W   = R3_W - FRAC_W;       // integer part of r^3
  localparam int AH_W   = COEF_W + HI_W + 1;
  localparam int AL_W   = COEF_W + FRAC_W + 1;
  localparam int B_W    = COEF_W + R2_W + 1;
  localparam int TC_W   = COEF_W + R_W + 1;
  localparam int SUM_W  = 56;
  localparam int PROD_W = 2 * COEF_W;

  localparam logic signed [COEF_W-1:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [COEF_W-1:0] ONE_LSB  = 32'sd1;
  localparam logic signed [PROD_W-1:0] SAT_MAX  = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN  = -64'sd2147483648;
  localparam logic signed [COEF_W-1:0] POS_FULL = 32'sh7FFFFFFF;
  localparam logic signed [COEF_W-1:0] NEG_FULL = 32'sh80000000;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_ax;
    logic signed [COEF_W-1:0] coef_az;
    logic signed [COEF_W-1:0] coef_bx;
    logic signed [COEF_W-1:0] coef_bz;
    logic signed [COEF_W-1:0] coef_cx;
    logic signed [COEF_W-1:0] coef_cz;
    logic signed [COEF_W-1:0] coef_dx;
    logic signed [COEF_W-1:0] coef_dz;
    logic                     final_segment;
  } in_beat_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] x_low;
    logic signed [COEF_W-1:0] z_low;
    logic signed [COEF_W-1:0] x_high;
    logic signed [COEF_W-1:0] z_high;
    logic                     closes_contour;
    logic                     last_point;
  } out_beat_t;

  typedef struct packed {
    logic [STEP_W-1:0]        step_count;
    logic [INC_W-1:0]         param_increment;
    logic signed [COEF_W-1:0] height_low;
    logic signed [COEF_W-1:0] height_high;
    logic                     conic_mode;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch coefficients, restart r
    logic issue;  // launch one point
    logic last;   // launched point is the segment's last
    logic fin;    // segment closes the outline
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv;        // point pipeline advances this cycle
    logic coef_busy;  // coefficient registers still read by points in flight
  } status_t;

  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [COEF_W-1:0] res;
    if (v > SAT_MAX) begin
      res = POS_FULL;
    end else if (v < SAT_MIN) begin
      res = NEG_FULL;
    end else begin
      res = v[COEF_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/cpot_stream_if.sv =====
interface cpot_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cpot_cfg_regs.sv =====
module cpot_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cpot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpot_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cpot_pkg::cfg_t                   cfg
);
  import cpot_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_count      <= STEP_W'(16);
      cfg_r.param_increment <= INC_W'(4096);
      cfg_r.height_low      <= '0;
      cfg_r.height_high     <= ONE_Q16;
      cfg_r.conic_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_COUNT:      cfg_r.step_count      <= cfg_wdata[STEP_W-1:0];
        REG_PARAM_INCREMENT: cfg_r.param_increment <= cfg_wdata[INC_W-1:0];
        REG_HEIGHT_LOW:      cfg_r.height_low      <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_HEIGHT_HIGH:     cfg_r.height_high     <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_CONIC_MODE:      cfg_r.conic_mode      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/cpot_ctrl.sv =====
`include "cubic_prism_outline_tessellator_assert.svh"

module cpot_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  cpot_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  input  cpot_pkg::status_t   st,
  output cpot_pkg::cmd_t      cmd
);
  import cpot_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [STEP_W-1:0] k_r, k_nxt;
  logic [STEP_W-1:0] last_k_r, last_k_nxt;
  logic              fin_r, fin_nxt;
  logic [STEP_W-1:0] steps;
  logic              accept;

  // zero steps counts as one, clamp to the maximum
  always_comb begin
    if (cfg.step_count == '0) begin
      steps = STEP_W'(1);
    end else if (cfg.step_count > STEP_W'(MAX_STEPS)) begin
      steps = STEP_W'(MAX_STEPS);
    end else begin
      steps = cfg.step_count;
    end
  end

  assign in_ready  = (state_r == ST_IDLE) && !st.coef_busy;
  assign accept    = in_valid && in_ready;

  assign cmd.load  = accept;
  assign cmd.issue = (state_r == ST_RUN) && st.adv;
  assign cmd.last  = (k_r == last_k_r);
  assign cmd.fin   = fin_r;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    last_k_nxt = last_k_r;
    fin_nxt    = fin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_RUN;
          k_nxt      = '0;
          // final segment drops its closing point
          last_k_nxt = in_final ? steps - STEP_W'(1) : steps;
          fin_nxt    = in_final;
        end
      end
      ST_RUN: begin
        if (cmd.issue) begin
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + STEP_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      last_k_r <= '0;
      fin_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      last_k_r <= last_k_nxt;
      fin_r    <= fin_nxt;
    end
  end

  `CPOT_ASSERT_NXT(a_last_issue_idles, clk, rst_n, cmd.issue && cmd.last,
                   state_r == ST_IDLE, "controller kept running after last point")
  `CPOT_ASSERT_IMP(a_k_in_range, clk, rst_n, state_r == ST_RUN,
                   k_r <= last_k_r, "point index ran past segment end")

endmodule

// ===== hw/rtl/cpot_datapath.sv =====
`include "cubic_prism_outline_tessellator_assert.svh"

module cpot_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpot_pkg::cfg_t       cfg,
  input  cpot_pkg::in_beat_t   in_data,
  input  cpot_pkg::cmd_t       cmd,
  output cpot_pkg::status_t    st,
  input  logic                 out_ready,
  output logic                 out_valid,
  output cpot_pkg::out_beat_t  out_data
);
  import cpot_pkg::*;

  logic adv;

  // segment coefficients
  logic signed [COEF_W-1:0] ax_r, az_r, bx_r, bz_r, cx_r, cz_r, dx_r, dz_r;
  logic [R_W-1:0]           r_acc_r;

  // stage valids and flags
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic last1_r, last2_r, last3_r, last4_r, last5_r, last6_r;
  logic fin1_r, fin2_r, fin3_r, fin4_r, fin5_r;

  // stage 1: r, r*r
  logic [R_W-1:0]  r1_r;
  logic [RR_W-1:0] rr1_r;
  // stage 2: r^2, r^2*r, C*r
  logic [R2_W-1:0]          r2;
  logic [R2_W-1:0]          r2_2_r;
  logic [R2R_W-1:0]         r2r2_r;
  logic signed [TC_W-1:0]   tcx2_r, tcz2_r;
  // stage 3: A*r^3 in two parts, B*r^2, C term plus D
  logic [R3_W-1:0]          r3;
  logic [HI_W-1:0]          r3_hi;
  logic [FRAC_W-1:0]        r3_lo;
  logic signed [AH_W-1:0]   ahx3_r, ahz3_r;
  logic signed [AL_W-1:0]   alx3_r, alz3_r;
  logic signed [B_W-1:0]    bx3_r, bz3_r;
  logic signed [SUM_W-1:0]  tcdx3_r, tcdz3_r;
  // stage 4: partial sums
  logic signed [SUM_W-1:0]  tax4_r, taz4_r, tbx4_r, tbz4_r;
  // stage 5: saturated point
  logic signed [COEF_W-1:0] px5_r, pz5_r;
  // stage 6: scaled products
  logic signed [PROD_W-1:0] pxl6_r, pzl6_r, pxh6_r, pzh6_r;
  logic                     closes6_r;
  out_beat_t                out_data_r;

  // contour tracking
  logic signed [COEF_W-1:0] cs_x_r, cs_z_r;
  logic                     start_pending_r;
  logic                     closes;

  logic signed [COEF_W-1:0] h_low, h_high;

  assign adv = !out_valid_r || out_ready;
  assign st.adv       = adv;
  assign st.coef_busy = v1_r || v2_r;

  // zero height becomes one LSB in conic mode
  always_comb begin
    if (cfg.conic_mode) begin
      h_low  = (cfg.height_low  == '0) ? ONE_LSB : cfg.height_low;
      h_high = (cfg.height_high == '0) ? ONE_LSB : cfg.height_high;
    end else begin
      h_low  = ONE_Q16;
      h_high = ONE_Q16;
    end
  end

  assign r2    = rr1_r[RR_W-1:FRAC_W];
  assign r3    = r2r2_r[R2R_W-1:FRAC_W];
  assign r3_hi = r3[R3_W-1:FRAC_W];
  assign r3_lo = r3[FRAC_W-1:0];

  assign closes = !start_pending_r && (px5_r == cs_x_r) && (pz5_r == cs_z_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= in_data.coef_ax;
      az_r <= in_data.coef_az;
      bx_r <= in_data.coef_bx;
      bz_r <= in_data.coef_bz;
      cx_r <= in_data.coef_cx;
      cz_r <= in_data.coef_cz;
      dx_r <= in_data.coef_dx;
      dz_r <= in_data.coef_dz;
    end
  end

  // r stepped by addition, exact k * increment
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_acc_r <= '0;
    end else if (cmd.issue) begin
      r_acc_r <= r_acc_r + R_W'(cfg.param_increment);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1_r <= cmd.last;
      fin1_r  <= cmd.fin;
      r1_r    <= r_acc_r;
      rr1_r   <= r_acc_r * r_acc_r;

      last2_r <= last1_r;
      fin2_r  <= fin1_r;
      r2_2_r  <= r2;
      r2r2_r  <= r2 * r1_r;
      tcx2_r  <= cx_r * $signed({1'b0, r1_r});
      tcz2_r  <= cz_r * $signed({1'b0, r1_r});

      last3_r <= last2_r;
      fin3_r  <= fin2_r;
      ahx3_r  <= ax_r * $signed({1'b0, r3_hi});
      ahz3_r  <= az_r * $signed({1'b0, r3_hi});
      alx3_r  <= ax_r * $signed({1'b0, r3_lo});
      alz3_r  <= az_r * $signed({1'b0, r3_lo});
      bx3_r   <= bx_r * $signed({1'b0, r2_2_r});
      bz3_r   <= bz_r * $signed({1'b0, r2_2_r});
      tcdx3_r <= SUM_W'(tcx2_r >>> FRAC_W) + SUM_W'(dx_r);
      tcdz3_r <= SUM_W'(tcz2_r >>> FRAC_W) + SUM_W'(dz_r);

      last4_r <= last3_r;
      fin4_r  <= fin3_r;
      tax4_r  <= SUM_W'(ahx3_r) + SUM_W'(alx3_r >>> FRAC_W);
      taz4_r  <= SUM_W'(ahz3_r) + SUM_W'(alz3_r >>> FRAC_W);
      tbx4_r  <= SUM_W'(bx3_r >>> FRAC_W) + tcdx3_r;
      tbz4_r  <= SUM_W'(bz3_r >>> FRAC_W) + tcdz3_r;

      last5_r <= last4_r;
      fin5_r  <= fin4_r;
      px5_r   <= sat32(PROD_W'(tax4_r + tbx4_r));
      pz5_r   <= sat32(PROD_W'(taz4_r + tbz4_r));

      last6_r   <= last5_r;
      closes6_r <= closes;
      pxl6_r    <= px5_r * h_low;
      pzl6_r    <= pz5_r * h_low;
      pxh6_r    <= px5_r * h_high;
      pzh6_r    <= pz5_r * h_high;

      out_data_r.x_low          <= sat32(pxl6_r >>> FRAC_W);
      out_data_r.z_low          <= sat32(pzl6_r >>> FRAC_W);
      out_data_r.x_high         <= sat32(pxh6_r >>> FRAC_W);
      out_data_r.z_high         <= sat32(pzh6_r >>> FRAC_W);
      out_data_r.closes_contour <= closes6_r;
      out_data_r.last_point     <= last6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      v3_r            <= 1'b0;
      v4_r            <= 1'b0;
      v5_r            <= 1'b0;
      v6_r            <= 1'b0;
      out_valid_r     <= 1'b0;
      cs_x_r          <= '0;
      cs_z_r          <= '0;
      start_pending_r <= 1'b1;
    end else begin
      if (adv) begin
        v1_r        <= cmd.issue;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        v5_r        <= v4_r;
        v6_r        <= v5_r;
        out_valid_r <= v6_r;
      end
      // contour start / close, in point order
      if (adv && v5_r) begin
        if (start_pending_r) begin
          cs_x_r          <= px5_r;
          cs_z_r          <= pz5_r;
          start_pending_r <= 1'b0;
        end else if (closes) begin
          start_pending_r <= 1'b1;
        end
        if (last5_r && fin5_r) begin
          start_pending_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CPOT_ASSERT_IMP(a_issue_on_adv, clk, rst_n, cmd.issue, adv,
                   "point launched into a frozen pipeline")
  `CPOT_ASSERT_NXT(a_outline_end_rearms, clk, rst_n, adv && v5_r && last5_r && fin5_r,
                   start_pending_r, "outline end did not rearm contour start")

endmodule

// ===== hw/rtl/cubic_prism_outline_tessellator.sv =====
// Cubic prism outline tessellator.
// Input channel in_stream: one beat per cubic segment (x/z coefficients A..D,
// Q16.16, plus final_segment). Result channel out_stream: one beat per point,
// the point at the low and high prism heights, closes_contour and last_point.
// Config port cfg_*: plain write, register index as listed in cpot_pkg; write
// only while the block is idle.
// A segment gives step_count+1 points (step_count on a final segment; a zero
// step_count counts as one). Within a segment, points leave a 7-deep pipeline
// at one per cycle while out_stream is ready. The next segment beat is taken
// only once the previous segment's last point is launched and has passed the
// stages that read the coefficients. The pace is set by the single point
// pipeline and the shared coefficient registers.
// Reset: configuration returns to its defaults, the pipeline empties and the
// next point starts a new contour.
// A stall on out_stream freezes the whole point pipeline; no beat is dropped
// or repeated, and in_stream is held off until the coefficients are free.
module cubic_prism_outline_tessellator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [cpot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpot_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  cpot_stream_if.sink                      in_stream,
  cpot_stream_if.source                    out_stream
);
  import cpot_pkg::*;

  cfg_t      cfg;
  cmd_t      cmd;
  status_t   st;
  in_beat_t  in_data;
  out_beat_t out_data;
  logic      in_ready;
  logic      out_valid;

  assign in_data = in_stream.data;

  // configuration registers
  cpot_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // segment sequencer: takes a beat, launches one point per advancing cycle
  cpot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_stream.valid),
    .in_final (in_data.final_segment),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // point pipeline: powers of r, cubic terms, saturate, contour check, scale
  cpot_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_stream.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid;
  assign out_stream.data  = out_data;

endmodule

// ===== dv/cpot_point_checker.sv =====
module cpot_point_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cpot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpot_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  cpot_pkg::in_beat_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  cpot_pkg::out_beat_t             out_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpot_pkg::*;

  cfg_t                     active_cfg;
  logic signed [COEF_W-1:0] loop_x0;
  logic signed [COEF_W-1:0] loop_z0;
  logic                     need_start;
  out_beat_t                expected_points[$];

  function automatic logic signed [COEF_W-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return POS_FULL;
    if (v < -64'sd2147483648) return NEG_FULL;
    return v[COEF_W-1:0];
  endfunction

  // A term split into integer and fraction parts of r^3 keeps the product exact
  function automatic logic signed [COEF_W-1:0] cubic_at(
    input logic signed [COEF_W-1:0] a, b, c, d,
    input longint r, r2, r3);
    longint whole;
    longint frac;
    longint term_a;
    whole  = r3 >>> FRAC_W;
    frac   = r3 & 64'hFFFF;
    term_a = longint'(a) * whole + ((longint'(a) * frac) >>> FRAC_W);
    return clamp32(term_a + ((longint'(b) * r2) >>> FRAC_W)
                   + ((longint'(c) * r) >>> FRAC_W) + longint'(d));
  endfunction

  function automatic logic signed [COEF_W-1:0] scale_point(
    input logic signed [COEF_W-1:0] p, h);
    return clamp32((longint'(p) * longint'(h)) >>> FRAC_W);
  endfunction

  function automatic void tessellate_segment(input in_beat_t seg);
    int unsigned              steps;
    int unsigned              points;
    longint                   r, r2, r3;
    logic signed [COEF_W-1:0] px, pz, h_lo, h_hi;
    out_beat_t                pt;
    steps = active_cfg.step_count;
    if (steps == 0) steps = 1;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    // final segment drops its end point
    points = seg.final_segment ? steps : steps + 1;
    h_lo = ONE_Q16;
    h_hi = ONE_Q16;
    if (active_cfg.conic_mode) begin
      h_lo = (active_cfg.height_low == 0) ? ONE_LSB : active_cfg.height_low;
      h_hi = (active_cfg.height_high == 0) ? ONE_LSB : active_cfg.height_high;
    end
    for (int unsigned k = 0; k < points; k++) begin
      r  = longint'(k) * longint'(active_cfg.param_increment);
      r2 = (r * r) >>> FRAC_W;
      r3 = (r2 * r) >>> FRAC_W;
      px = cubic_at(seg.coef_ax, seg.coef_bx, seg.coef_cx, seg.coef_dx, r, r2, r3);
      pz = cubic_at(seg.coef_az, seg.coef_bz, seg.coef_cz, seg.coef_dz, r, r2, r3);
      pt.closes_contour = 1'b0;
      if (need_start) begin
        loop_x0    = px;
        loop_z0    = pz;
        need_start = 1'b0;
      end else if (px == loop_x0 && pz == loop_z0) begin
        pt.closes_contour = 1'b1;
        need_start        = 1'b1;
      end
      pt.x_low      = scale_point(px, h_lo);
      pt.z_low      = scale_point(pz, h_lo);
      pt.x_high     = scale_point(px, h_hi);
      pt.z_high     = scale_point(pz, h_hi);
      pt.last_point = (k + 1 == points);
      expected_points = {expected_points, pt};
    end
    if (seg.final_segment) need_start = 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      active_cfg = '{6'd16, 17'd4096, 32'sd0, ONE_Q16, 1'b0};
      loop_x0    = '0;
      loop_z0    = '0;
      need_start = 1'b1;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_COUNT:      active_cfg.step_count      = cfg_wdata[STEP_W-1:0];
          REG_PARAM_INCREMENT: active_cfg.param_increment = cfg_wdata[INC_W-1:0];
          REG_HEIGHT_LOW:      active_cfg.height_low      = cfg_wdata[COEF_W-1:0];
          REG_HEIGHT_HIGH:     active_cfg.height_high     = cfg_wdata[COEF_W-1:0];
          REG_CONIC_MODE:      active_cfg.conic_mode      = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) tessellate_segment(in_data);
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("point beat arrived with no point expected");
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("x_low", want.x_low, out_data.x_low);
          check_field("z_low", want.z_low, out_data.z_low);
          check_field("x_high", want.x_high, out_data.x_high);
          check_field("z_high", want.z_high, out_data.z_high);
          check_field("closes_contour", want.closes_contour, out_data.closes_contour);
          check_field("last_point", want.last_point, out_data.last_point);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

// ===== dv/cubic_prism_outline_tessellator_tb.sv =====
module cubic_prism_outline_tessellator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpot_pkg::*;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int TARGET_ITEMS   = 450;
  localparam int RX_HOLD_CYCLES = 300;   // long enough to back up pipe and input
  localparam int DRAIN_CYCLES   = 40;    // well past the time a point takes through the pipeline
  // worst run: every item 64 points, each behind the longest random stall, x4 margin
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam logic signed [COEF_W-1:0] HALF_SPAN = 32'sh0010_0000;  // 16.0

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    items_sent;
  int                    tx_idle_pct;
  bit                    rx_hold_req;

  cpot_stream_if #(.payload_t(in_beat_t))  in_if ();
  cpot_stream_if #(.payload_t(out_beat_t)) out_if ();

  cubic_prism_outline_tessellator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  cpot_point_checker point_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_data    (in_if.data),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_data   (out_if.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // watchdog
  initial begin : cycle_guard
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 24);
    return $urandom_range(1, 3);
  endfunction

  // zero gives stretches with no idling at all
  function automatic int idle_pct_pick();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 12;
      default: return 45;
    endcase
  endfunction

  // coordinate or coefficient within +-16.0
  function automatic logic signed [COEF_W-1:0] coef_near();
    logic signed [COEF_W-1:0] v;
    v = $urandom_range(0, 2 * HALF_SPAN);
    return v - HALF_SPAN;
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_height();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ONE_Q16;
      2:       return coef_near() >>> 1;
      3:       return $urandom;
      4:       return POS_FULL;
      default: return NEG_FULL;
    endcase
  endfunction

  function automatic in_beat_t make_seg(
    input logic signed [COEF_W-1:0] ax, az, bx, bz, cx, cz, dx, dz,
    input logic fin);
    return '{ax, az, bx, bz, cx, cz, dx, dz, fin};
  endfunction

  // one input beat; valid stays up across back-to-back beats
  task automatic send_segment(input in_beat_t seg);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= seg;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_filled(input logic signed [COEF_W-1:0] v, input logic fin);
    send_segment(make_seg(v, v, v, v, v, v, v, v, fin));
  endtask

  // Well-formed outline: one or two closed contours of 1..4 curved segments.
  // At r = 1.0 a segment sits at A+B+C+D, so C is picked to land on the next
  // vertex; with a power-of-two step count the end point hits it exactly.
  task automatic send_outline();
    int                       n_loops;
    int                       n_segs;
    int                       nxt;
    logic signed [COEF_W-1:0] vx [4];
    logic signed [COEF_W-1:0] vz [4];
    in_beat_t                 seg;
    n_loops = $urandom_range(1, 2);
    for (int lp = 0; lp < n_loops; lp++) begin
      n_segs = $urandom_range(1, 4);
      for (int i = 0; i < n_segs; i++) begin
        vx[i] = coef_near();
        vz[i] = coef_near();
      end
      for (int i = 0; i < n_segs; i++) begin
        nxt         = (i + 1) % n_segs;
        seg.coef_ax = coef_near();
        seg.coef_az = coef_near();
        seg.coef_bx = coef_near();
        seg.coef_bz = coef_near();
        seg.coef_dx = vx[i];
        seg.coef_dz = vz[i];
        seg.coef_cx = vx[nxt] - vx[i] - seg.coef_ax - seg.coef_bx;
        seg.coef_cz = vz[nxt] - vz[i] - seg.coef_az - seg.coef_bz;
        // broken contour: vertex missed by a few LSBs
        if ($urandom_range(0, 11) == 0) seg.coef_cx = seg.coef_cx + $urandom_range(1, 3);
        seg.final_segment = (lp == n_loops - 1) && (i == n_segs - 1) &&
                            ($urandom_range(0, 3) != 0);
        send_segment(seg);
      end
    end
  endtask

  // Drop valid and hold until every expected point has come out. pending is
  // sampled on the falling edge so it never races the checker.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // all five registers, one write beat each, enable held across them
  task automatic apply_config(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_COUNT;
    cfg_wdata <= CFG_DATA_W'(c.step_count);
    @(posedge clk);
    cfg_index <= REG_PARAM_INCREMENT;
    cfg_wdata <= CFG_DATA_W'(c.param_increment);
    @(posedge clk);
    cfg_index <= REG_HEIGHT_LOW;
    cfg_wdata <= c.height_low;
    @(posedge clk);
    cfg_index <= REG_HEIGHT_HIGH;
    cfg_wdata <= c.height_high;
    @(posedge clk);
    cfg_index <= REG_CONIC_MODE;
    cfg_wdata <= CFG_DATA_W'(c.conic_mode);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off requested by the
  // stimulus so the pipe fills and in_stream backs up.
  initial begin : result_sink
    int idle_pct;
    bit held_off;
    idle_pct = 0;
    held_off = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) idle_pct = idle_pct_pick();
      if (rx_hold_req && !held_off) begin
        held_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_t phase_cfg;
    int   sel;
    int   phase_end;
    bit   paused;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    items_sent  = 0;
    tx_idle_pct = 0;
    rx_hold_req = 1'b0;
    paused      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset settings, 16 steps ----
    // constant origin: every second point closes, the next one restarts
    send_filled('0, 1'b0);
    // straight two-segment run (1,2) -> (5,-3) -> back; contour start is still the origin, so no close
    send_segment(make_seg('0, '0, '0, '0, 32'sh0004_0000, -32'sh0005_0000,
                          32'sh0001_0000, 32'sh0002_0000, 1'b0));
    send_segment(make_seg('0, '0, '0, '0, -32'sh0004_0000, 32'sh0005_0000,
                          32'sh0005_0000, -32'sh0003_0000, 1'b0));
    // saturation both ways
    send_filled(POS_FULL, 1'b0);
    send_filled(NEG_FULL, 1'b0);
    // final segment: end point dropped, outline restarts
    send_segment(make_seg(POS_FULL, NEG_FULL, NEG_FULL, POS_FULL,
                          POS_FULL, NEG_FULL, NEG_FULL, POS_FULL, 1'b1));
    send_filled('0, 1'b1);
    send_outline();

    // conic, zero low height scales by one LSB, negative upper height
    wait_drained();
    apply_config('{6'd4, 17'd16384, 32'sd0, -32'sh0003_0000, 1'b1});
    send_segment(make_seg('0, '0, '0, '0, '0, '0, 32'sh0002_8000, -32'sh0001_4000, 1'b0));
    send_filled(POS_FULL, 1'b0);
    send_segment(make_seg(coef_near(), coef_near(), coef_near(), coef_near(),
                          coef_near(), coef_near(), coef_near(), coef_near(), 1'b1));

    // step count zero runs as one step; heights at both extremes
    wait_drained();
    apply_config('{6'd0, 17'd65536, POS_FULL, NEG_FULL, 1'b1});
    send_segment(make_seg('0, '0, '0, '0, 32'sh0000_8000, -32'sh0000_8000,
                          32'sh0003_0000, -32'sh0002_0000, 1'b0));
    send_filled(POS_FULL, 1'b0);
    send_filled('0, 1'b1);

    // largest step count with the full 17-bit increment: widest r
    wait_drained();
    apply_config('{6'd63, 17'h1FFFF, -ONE_Q16, POS_FULL, 1'b0});
    send_filled(POS_FULL, 1'b0);
    send_filled(NEG_FULL, 1'b0);
    send_filled(ONE_Q16, 1'b1);

    // zero increment: every point is D; zero upper height in conic mode
    wait_drained();
    apply_config('{6'd63, 17'd0, ONE_Q16, 32'sd0, 1'b1});
    send_filled(ONE_LSB, 1'b0);
    send_filled(-ONE_Q16, 1'b1);

    // ---- random phases, new settings each, block idle between ----
    while (items_sent < TARGET_ITEMS) begin
      wait_drained();
      sel = $urandom_range(0, 5);
      if ($urandom_range(0, 3) != 0) begin
        // power-of-two steps, r reaches exactly 1.0 on the end point
        phase_cfg.step_count      = STEP_W'(1 << sel);
        phase_cfg.param_increment = INC_W'(32'h0001_0000 >> sel);
      end else begin
        phase_cfg.step_count      = STEP_W'($urandom_range(0, MAX_STEPS));
        phase_cfg.param_increment = INC_W'($urandom);
      end
      phase_cfg.height_low  = pick_height();
      phase_cfg.height_high = pick_height();
      phase_cfg.conic_mode  = 1'($urandom_range(0, 1));
      apply_config(phase_cfg);
      if (!rx_hold_req) begin
        // first phase: sender keeps offering while the sink holds off
        rx_hold_req = 1'b1;
        tx_idle_pct = 0;
      end else begin
        tx_idle_pct = idle_pct_pick();
      end
      phase_end = items_sent + $urandom_range(25, 45);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: full-range coefficients, random final flag
          send_segment(make_seg($urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom,
                                1'($urandom_range(0, 1))));
        end else begin
          send_outline();
        end
        if (!paused && items_sent >= TARGET_ITEMS / 2) begin
          // sender pauses until every queued point is out, same settings
          paused = 1'b1;
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
